// ===== rtl/core/hbn_pkg.sv =====
`default_nettype none
package hbn_pkg;

  localparam int NUM_BINS  = 64;
  localparam int BIN_WIDTH = 100;
  localparam int BIN_AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam int VALUE_W   = 16;
  localparam int COUNT_W   = 16;
  localparam int SCALE_W   = 8;
  localparam int INDEX_W   = 6;

  // Shared divider: dividend holds count*full_scale, divisor holds a count.
  localparam int DVD_W     = COUNT_W + SCALE_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // Binning by reciprocal multiply: (v * RECIP_M) >> RECIP_SH equals
  // floor(v / BIN_WIDTH) for every VALUE_W-bit v.
  localparam int RECIP_SH  = VALUE_W + $clog2(BIN_WIDTH);
  localparam int RECIP_W   = VALUE_W + 1;
  localparam int PROD_W    = VALUE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(BIN_WIDTH) - 64'd1) / 64'(BIN_WIDTH));

  localparam logic [SCALE_W-1:0] FULL_SCALE_RESET = SCALE_W'(60);
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [VALUE_W-1:0] sample_value;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [SCALE_W-1:0] bar_length;
    logic               last_bin;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/core/hbn_ram.sv =====
`default_nettype none
module hbn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/histogram_bin_and_normalize_top.sv =====
`default_nettype none
// Channel  | Ports                          | Payload
// ---------+--------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data    | hbn_pkg::in_t  (op, sample)
// result   | out_valid, out_ready, out_data | hbn_pkg::out_t (bin, count, bar)
// config   | cfg_valid, cfg_ready, cfg_data | full_scale, 8 bits
//
// A sample transaction: the bin comes from a reciprocal multiply in the shared
// multiplier as the sample is taken, then the bin counter is read and written
// back; a sample past the top bin is dropped with no write.
// A finish transaction walks every bin and can stall on the output register:
// each bin is read, scaled by full_scale in the shared multiplier,
// then divided by the peak in the restoring divider, one quotient bit a cycle.
// With a zero peak the divide is skipped.
// Reset (rst_n low, synchronous) clears all bin valid bits, so counters read
// zero at once; no clearing pass is needed. full_scale returns to 60.
module histogram_bin_and_normalize_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire hbn_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output hbn_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [hbn_pkg::SCALE_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,  // wait for a transaction
    ST_DIV  = 7'b0000010,  // divider iterating
    ST_LOOK = 7'b0000100,  // issue counter read for a sample
    ST_UPD  = 7'b0001000,  // increment and write back
    ST_FRD  = 7'b0010000,  // issue counter read for a finish bin
    ST_FMUL = 7'b0100000,  // scale count by full_scale
    ST_EMIT = 7'b1000000   // hand the bin result to the output register
  } state_t;

  state_t state_r, state_nxt;

  logic [hbn_pkg::SCALE_W-1:0]   full_scale_r;
  logic [hbn_pkg::COUNT_W-1:0]   peak_r, peak_nxt;
  logic [hbn_pkg::NUM_BINS-1:0]  vld_r, vld_nxt;
  logic [hbn_pkg::BIN_AW-1:0]    bin_cnt_r, bin_cnt_nxt;
  logic [hbn_pkg::BIN_AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic [hbn_pkg::COUNT_W-1:0]   cnt_r, cnt_nxt;

  // Shared restoring divider: dvd_r shifts out dividend and in quotient bits.
  logic [hbn_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [hbn_pkg::COUNT_W-1:0]   rem_r, rem_nxt;
  logic [hbn_pkg::COUNT_W-1:0]   dsr_r, dsr_nxt;
  logic [hbn_pkg::DIV_CNT_W-1:0] step_r, step_nxt;
  logic [hbn_pkg::COUNT_W:0]     trial;
  logic                          trial_ge;
  logic [hbn_pkg::COUNT_W:0]     trial_sub;

  // Shared multiplier: sample times reciprocal when idle, count times scale otherwise.
  logic [hbn_pkg::VALUE_W-1:0]   mul_a;
  logic [hbn_pkg::RECIP_W-1:0]   mul_b;
  logic [hbn_pkg::PROD_W-1:0]    mul_p;

  logic                          out_valid_r, out_valid_nxt;
  hbn_pkg::out_t                 out_data_r, out_data_nxt;

  logic                          ram_we;
  logic [hbn_pkg::BIN_AW-1:0]    ram_raddr;
  logic [hbn_pkg::COUNT_W-1:0]   ram_wdata;
  logic [hbn_pkg::COUNT_W-1:0]   ram_rdata;
  logic [hbn_pkg::COUNT_W-1:0]   rd_count;
  logic [hbn_pkg::COUNT_W-1:0]   inc_count;
  logic                          slot_free;
  logic                          last_bin;

  hbn_ram #(
    .WIDTH (hbn_pkg::COUNT_W),
    .DEPTH (hbn_pkg::NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (rd_addr_r),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A bin never written since the last clear reads as zero.
  assign rd_count  = vld_r[rd_addr_r] ? ram_rdata : '0;
  assign inc_count = (rd_count == hbn_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1;
  assign ram_wdata = inc_count;
  assign ram_we    = (state_r == ST_UPD);
  assign ram_raddr = (state_r == ST_LOOK) ? dvd_r[hbn_pkg::BIN_AW-1:0] : bin_cnt_r;

  assign trial     = {rem_r, dvd_r[hbn_pkg::DVD_W-1]};
  assign trial_ge  = (trial >= {1'b0, dsr_r});
  assign trial_sub = trial - {1'b0, dsr_r};

  assign mul_a = (state_r == ST_IDLE) ? in_data.sample_value : rd_count;
  assign mul_b = (state_r == ST_IDLE) ? hbn_pkg::RECIP_M
                                      : hbn_pkg::RECIP_W'(full_scale_r);
  assign mul_p = hbn_pkg::PROD_W'(mul_a) * hbn_pkg::PROD_W'(mul_b);

  assign slot_free = !out_valid_r || out_ready;
  assign last_bin  = (bin_cnt_r == hbn_pkg::BIN_AW'(hbn_pkg::NUM_BINS - 1));

  always_comb begin
    state_nxt     = state_r;
    peak_nxt      = peak_r;
    vld_nxt       = vld_r;
    bin_cnt_nxt   = bin_cnt_r;
    rd_addr_nxt   = rd_addr_r;
    cnt_nxt       = cnt_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    step_nxt      = step_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == hbn_pkg::OP_FINISH) begin
            bin_cnt_nxt = '0;
            state_nxt   = ST_FRD;
          end else begin
            // Take the bin number straight from the reciprocal product.
            dvd_nxt   = hbn_pkg::DVD_W'(mul_p[hbn_pkg::PROD_W-1:hbn_pkg::RECIP_SH]);
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_DIV: begin
        dvd_nxt  = {dvd_r[hbn_pkg::DVD_W-2:0], trial_ge};
        rem_nxt  = trial_ge ? trial_sub[hbn_pkg::COUNT_W-1:0] : trial[hbn_pkg::COUNT_W-1:0];
        step_nxt = step_r + 1'b1;
        if (step_r == hbn_pkg::DIV_CNT_W'(hbn_pkg::DVD_W - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_LOOK: begin
        // Drop samples past the last bin.
        if (dvd_r < hbn_pkg::DVD_W'(hbn_pkg::NUM_BINS)) begin
          rd_addr_nxt = dvd_r[hbn_pkg::BIN_AW-1:0];
          state_nxt   = ST_UPD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UPD: begin
        vld_nxt[rd_addr_r] = 1'b1;
        if (inc_count > peak_r) begin
          peak_nxt = inc_count;
        end
        state_nxt = ST_IDLE;
      end
      ST_FRD: begin
        rd_addr_nxt = bin_cnt_r;
        state_nxt   = ST_FMUL;
      end
      ST_FMUL: begin
        cnt_nxt = rd_count;
        if (peak_r == '0) begin
          dvd_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          dvd_nxt   = mul_p[hbn_pkg::DVD_W-1:0];
          rem_nxt   = '0;
          dsr_nxt   = peak_r;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_EMIT: begin
        // Hold until the output register is free.
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.bin_index  = hbn_pkg::INDEX_W'(bin_cnt_r);
          out_data_nxt.bin_count  = cnt_r;
          out_data_nxt.bar_length = dvd_r[hbn_pkg::SCALE_W-1:0];
          out_data_nxt.last_bin   = last_bin;
          if (last_bin) begin
            vld_nxt   = '0;
            peak_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            bin_cnt_nxt = bin_cnt_r + 1'b1;
            state_nxt   = ST_FRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      full_scale_r <= hbn_pkg::FULL_SCALE_RESET;
      peak_r       <= '0;
      vld_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      peak_r      <= peak_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        full_scale_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_cnt_r  <= bin_cnt_nxt;
    rd_addr_r  <= rd_addr_nxt;
    cnt_r      <= cnt_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/hbn_checker.sv =====
`default_nettype none
module hbn_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire hbn_pkg::out_t               out_data
);

  // An accepted transaction makes input ready drop in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The final result carries the top bin index.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_bin |->
      out_data.bin_index == hbn_pkg::INDEX_W'(hbn_pkg::NUM_BINS - 1))
    else $error("last_bin on a bin other than the final one");

  // No new transaction while a histogram dump is still under way.
  a_no_accept_mid_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_bin |-> !in_ready)
    else $error("input ready during a histogram dump");

endmodule

bind histogram_bin_and_normalize_top hbn_checker u_hbn_checker (.*);
`default_nettype wire

// ===== tb/histogram_bin_and_normalize_top_tb.sv =====
`timescale 1ns / 1ps
module histogram_bin_and_normalize_top_tb;

  // Bound on a run that never hangs: every item a finish, every bin report
  // slowed by divider and receiver stalls, then taken several times over.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // Quiet time before a register write or the end of the run. It covers a
  // sample still being binned, which has no report to wait for.
  localparam int SETTLE_CYCLES = 2 * (hbn_pkg::DVD_W + 4);
  localparam int RANDOM_ITEMS  = 236;

  // Running copy of the binning state. It turns each accepted transaction
  // into the bin reports that the block should produce.
  class histogram_tracker;
    logic [hbn_pkg::COUNT_W-1:0] counts [hbn_pkg::NUM_BINS];
    logic [hbn_pkg::COUNT_W-1:0] peak;
    logic [hbn_pkg::SCALE_W-1:0] scale;
    hbn_pkg::out_t               pending_reports [$];
    int unsigned                 mismatches;

    function new();
      clear_bins();
      scale = hbn_pkg::FULL_SCALE_RESET;
      mismatches = 0;
    endfunction

    function void clear_bins();
      foreach (counts[b]) counts[b] = '0;
      peak = '0;
    endfunction

    function void set_scale(logic [hbn_pkg::SCALE_W-1:0] value);
      scale = value;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void absorb_item(hbn_pkg::in_t item);
      int unsigned               bin;
      logic [hbn_pkg::DVD_W-1:0] product;
      hbn_pkg::out_t             report;
      if (item.operation == hbn_pkg::OP_SAMPLE) begin
        bin = item.sample_value / hbn_pkg::BIN_WIDTH;
        // Drop samples past the top bin; saturate a full counter.
        if (bin < hbn_pkg::NUM_BINS) begin
          if (counts[bin] != hbn_pkg::COUNT_MAX) counts[bin] = counts[bin] + 1'b1;
          if (counts[bin] > peak) peak = counts[bin];
        end
      end else begin
        for (int b = 0; b < hbn_pkg::NUM_BINS; b++) begin
          report.bin_index  = hbn_pkg::INDEX_W'(b);
          report.bin_count  = counts[b];
          report.last_bin   = (b == hbn_pkg::NUM_BINS - 1);
          report.bar_length = '0;
          if (peak != '0) begin
            product = hbn_pkg::DVD_W'(counts[b]) * hbn_pkg::DVD_W'(scale);
            report.bar_length = hbn_pkg::SCALE_W'(product / hbn_pkg::DVD_W'(peak));
          end
          pending_reports.push_back(report);
        end
        clear_bins();
      end
    endfunction

    function void compare_field(string name, logic [hbn_pkg::COUNT_W-1:0] expv,
                                logic [hbn_pkg::COUNT_W-1:0] actv);
      if (actv !== expv) begin
        $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
        mismatches++;
      end
    endfunction

    function void check_report(hbn_pkg::out_t got);
      hbn_pkg::out_t want;
      if (pending_reports.size() == 0) begin
        $error("bin report with none outstanding: bin_index %0d", got.bin_index);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("bin_index", hbn_pkg::COUNT_W'(want.bin_index),
                    hbn_pkg::COUNT_W'(got.bin_index));
      compare_field("bin_count", want.bin_count, got.bin_count);
      compare_field("bar_length", hbn_pkg::COUNT_W'(want.bar_length),
                    hbn_pkg::COUNT_W'(got.bar_length));
      compare_field("last_bin", hbn_pkg::COUNT_W'(want.last_bin),
                    hbn_pkg::COUNT_W'(got.last_bin));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  hbn_pkg::in_t                in_data = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  hbn_pkg::out_t               out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [hbn_pkg::SCALE_W-1:0] cfg_data = '0;

  // When set, neither side idles: back-to-back transactions and no stalls.
  logic               steady = 1'b0;
  int unsigned        cycle_count = 0;

  histogram_tracker tracker = new();

  histogram_bin_and_normalize_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random, with a chance of 28 in 100, unless steady is set.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99, 0) >= 28);
  end

  // Check every accepted bin report against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_report(out_data);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one transaction, optionally after an idle gap, and hold it until the
  // block takes it. Valid stays high afterwards so the next call can follow
  // back to back.
  task automatic send_item(logic op, logic [hbn_pkg::VALUE_W-1:0] value);
    hbn_pkg::in_t item;
    item.operation    = op;
    item.sample_value = value;
    if (!steady && $urandom_range(99, 0) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.absorb_item(item);
  endtask

  // Drop valid and hold off until every predicted report has arrived.
  // With settle set, also give a sample in flight time to retire.
  task automatic drain(bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write full_scale only once the block has gone quiet.
  task automatic write_scale(logic [hbn_pkg::SCALE_W-1:0] value);
    drain(1'b1);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_scale(value);
  endtask

  initial begin
    int          sent;
    int          run_len;
    int unsigned hot_bin;
    int unsigned pick;
    logic [hbn_pkg::VALUE_W-1:0] value;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Empty histogram straight out of reset: every bar is zero.
    send_item(hbn_pkg::OP_FINISH, 16'h0000);
    drain(1'b0);

    // Bin edges, the top bin, samples past the top bin, and alternating bits.
    send_item(hbn_pkg::OP_SAMPLE, 16'd0);
    send_item(hbn_pkg::OP_SAMPLE, 16'd99);
    send_item(hbn_pkg::OP_SAMPLE, 16'd100);
    send_item(hbn_pkg::OP_SAMPLE, 16'd6300);
    send_item(hbn_pkg::OP_SAMPLE, 16'd6399);
    send_item(hbn_pkg::OP_SAMPLE, 16'd6399);
    send_item(hbn_pkg::OP_SAMPLE, 16'd6400);
    send_item(hbn_pkg::OP_SAMPLE, 16'hFFFF);
    send_item(hbn_pkg::OP_SAMPLE, 16'hAAAA);
    send_item(hbn_pkg::OP_SAMPLE, 16'h5555);
    send_item(hbn_pkg::OP_FINISH, 16'hFFFF);

    // Largest full scale.
    write_scale(8'd255);
    send_item(hbn_pkg::OP_SAMPLE, 16'd500);
    send_item(hbn_pkg::OP_SAMPLE, 16'd501);
    send_item(hbn_pkg::OP_SAMPLE, 16'd599);
    send_item(hbn_pkg::OP_SAMPLE, 16'd1000);
    send_item(hbn_pkg::OP_FINISH, 16'h1234);

    // Zero full scale flattens every bar.
    write_scale(8'd0);
    send_item(hbn_pkg::OP_SAMPLE, 16'd42);
    send_item(hbn_pkg::OP_SAMPLE, 16'd4242);
    send_item(hbn_pkg::OP_FINISH, 16'h0000);

    // Smallest nonzero full scale.
    write_scale(8'd1);
    send_item(hbn_pkg::OP_SAMPLE, 16'd7);
    send_item(hbn_pkg::OP_SAMPLE, 16'd3333);
    send_item(hbn_pkg::OP_SAMPLE, 16'd3333);
    send_item(hbn_pkg::OP_FINISH, 16'h8000);

    // Random bursts of samples around a hot bin, each closed by a finish.
    // Some bursts are empty or long; a few samples land past the top bin.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      run_len = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 30)
                                            : $urandom_range(25, 0);
      hot_bin = $urandom_range(hbn_pkg::NUM_BINS - 1, 0);
      for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(99, 0);
        if (pick < 10)
          value = hbn_pkg::VALUE_W'($urandom_range(65535,
                                     hbn_pkg::NUM_BINS * hbn_pkg::BIN_WIDTH));
        else if (pick < 55)
          value = hbn_pkg::VALUE_W'(hot_bin * hbn_pkg::BIN_WIDTH
                                    + $urandom_range(hbn_pkg::BIN_WIDTH - 1, 0));
        else if (pick < 65)
          value = hbn_pkg::VALUE_W'(((hot_bin + 1) % hbn_pkg::NUM_BINS)
                                    * hbn_pkg::BIN_WIDTH
                                    + $urandom_range(hbn_pkg::BIN_WIDTH - 1, 0));
        else
          value = hbn_pkg::VALUE_W'($urandom_range(
                                     hbn_pkg::NUM_BINS * hbn_pkg::BIN_WIDTH - 1, 0));
        steady <= (sent >= 90 && sent < 160);
        send_item(hbn_pkg::OP_SAMPLE, value);
        sent++;
      end
      steady <= (sent >= 90 && sent < 160);
      send_item(hbn_pkg::OP_FINISH, hbn_pkg::VALUE_W'($urandom_range(65535, 0)));
      sent++;
      // Between histograms: sometimes retune the scale, sometimes just wait
      // for the walk to finish before sending more.
      if ($urandom_range(3, 0) == 0)
        write_scale(hbn_pkg::SCALE_W'($urandom_range(255, 0)));
      else if ($urandom_range(4, 0) == 0)
        drain(1'b0);
    end

    steady <= 1'b0;
    drain(1'b1);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
